>>> hdl/ntw_pkg.sv
// Shared types, constants and functions for the number-to-word-tokens block.
// No dependencies; used by every module in hdl/.
package ntw_pkg;

  localparam int unsigned ValueW    = 30;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned DigitCnt  = 9;
  localparam int unsigned BcdW      = DigitW * DigitCnt;
  localparam int unsigned CodeW     = 5;
  localparam int unsigned GroupCnt  = 3;
  localparam int unsigned SlotCnt   = 5;
  localparam int unsigned TokenCnt  = GroupCnt * SlotCnt + 1;
  localparam int unsigned PosW      = $clog2(TokenCnt);
  localparam int unsigned StepCnt   = ValueW / 2;
  localparam int unsigned StepW     = $clog2(StepCnt);

  localparam logic [ValueW-1:0] MaxValue = ValueW'(999999999);

  localparam logic [CodeW-1:0] CodeEol      = CodeW'(0);
  localparam logic [CodeW-1:0] CodeTeenBase = CodeW'(10);
  localparam logic [CodeW-1:0] CodeTensBase = CodeW'(18);
  localparam logic [CodeW-1:0] CodeHundred  = CodeW'(28);
  localparam logic [CodeW-1:0] CodeThousand = CodeW'(29);
  localparam logic [CodeW-1:0] CodeMillion  = CodeW'(30);

  // token slots inside one group
  localparam int unsigned SlotHundDigit = 0;
  localparam int unsigned SlotHundWord  = 1;
  localparam int unsigned SlotTens      = 2;
  localparam int unsigned SlotOnes      = 3;
  localparam int unsigned SlotScale     = 4;

  typedef logic [BcdW-1:0] bcd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_HOLD
  } front_state_e;

  // one double-dabble step: adjust digits, shift in one binary bit
  function automatic bcd_t dabble_step(input bcd_t bcd, input logic b);
    bcd_t adj;
    adj = bcd;
    for (int d = 0; d < DigitCnt; d++) begin
      if (bcd[DigitW*d +: DigitW] >= DigitW'(5)) begin
        adj[DigitW*d +: DigitW] = bcd[DigitW*d +: DigitW] + DigitW'(3);
      end
    end
    return {adj[BcdW-2:0], b};
  endfunction

  // which token positions are emitted for a number in BCD
  function automatic logic [TokenCnt-1:0] token_mask(input bcd_t bcd);
    logic [TokenCnt-1:0] m;
    logic [DigitW-1:0]   h;
    logic [DigitW-1:0]   t;
    logic [DigitW-1:0]   o;
    m = '0;
    for (int g = 0; g < GroupCnt; g++) begin
      h = bcd[DigitW*(DigitCnt-1-3*g) +: DigitW];
      t = bcd[DigitW*(DigitCnt-2-3*g) +: DigitW];
      o = bcd[DigitW*(DigitCnt-3-3*g) +: DigitW];
      m[SlotCnt*g+SlotHundDigit] = (h != '0);
      m[SlotCnt*g+SlotHundWord]  = (h != '0);
      m[SlotCnt*g+SlotTens]      = (t != '0);
      m[SlotCnt*g+SlotOnes]      = (t != DigitW'(1)) && (o != '0);
      m[SlotCnt*g+SlotScale]     = (g < GroupCnt - 1) && ((h | t | o) != '0);
    end
    m[TokenCnt-1] = 1'b1;
    return m;
  endfunction

  // word code at a token position
  function automatic logic [CodeW-1:0] token_code(input bcd_t bcd,
                                                  input logic [PosW-1:0] pos);
    logic [CodeW-1:0]  codes [TokenCnt];
    logic [DigitW-1:0] h;
    logic [DigitW-1:0] t;
    logic [DigitW-1:0] o;
    for (int g = 0; g < GroupCnt; g++) begin
      h = bcd[DigitW*(DigitCnt-1-3*g) +: DigitW];
      t = bcd[DigitW*(DigitCnt-2-3*g) +: DigitW];
      o = bcd[DigitW*(DigitCnt-3-3*g) +: DigitW];
      codes[SlotCnt*g+SlotHundDigit] = CodeW'(h);
      codes[SlotCnt*g+SlotHundWord]  = CodeHundred;
      codes[SlotCnt*g+SlotTens]      = (t == DigitW'(1)) ? CodeTeenBase + CodeW'(o)
                                                         : CodeTensBase + CodeW'(t);
      codes[SlotCnt*g+SlotOnes]      = CodeW'(o);
      codes[SlotCnt*g+SlotScale]     = (g == 0) ? CodeMillion : CodeThousand;
    end
    codes[TokenCnt-1] = CodeEol;
    return codes[pos];
  endfunction

endpackage

>>> hdl/ntw_fifo.sv
// Two-entry queue of BCD numbers between front and back.
// Depends on ntw_pkg.
module ntw_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ntw_pkg::bcd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ntw_pkg::bcd_t pop_data_o
);
  import ntw_pkg::*;

  bcd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;
  logic       do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/ntw_front.sv
// Front end: accepts a number, saturates it and converts it to BCD,
// two bits per cycle. Depends on ntw_pkg.
module ntw_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ntw_pkg::ValueW-1:0] value_i,
  output logic                      push_o,
  output ntw_pkg::bcd_t             push_data_o,
  input  logic                      fifo_full_i
);
  import ntw_pkg::*;

  localparam logic [StepW-1:0] LastStep = StepW'(StepCnt - 1);

  front_state_e      state_q, state_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic [ValueW-1:0] bin_q;
  bcd_t              bcd_q;
  bcd_t              step1;
  bcd_t              step2;
  logic              accept;
  logic              conv_done;

  assign step1     = dabble_step(bcd_q, bin_q[ValueW-1]);
  assign step2     = dabble_step(step1, bin_q[ValueW-2]);
  assign conv_done = (state_q == F_CONV) && (cnt_q == LastStep);
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) state_d = F_CONV;
      end
      F_CONV: begin
        if (cnt_q == LastStep) begin
          if (fifo_full_i) state_d = F_HOLD;
          else state_d = in_valid_i ? F_CONV : F_IDLE;
        end
      end
      F_HOLD: begin
        if (!fifo_full_i) state_d = in_valid_i ? F_CONV : F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    push_data_o = step2;
    unique case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
      end
      F_CONV: begin
        push_o     = conv_done && !fifo_full_i;
        in_ready_o = conv_done && !fifo_full_i;
      end
      F_HOLD: begin
        push_o      = !fifo_full_i;
        in_ready_o  = !fifo_full_i;
        push_data_o = bcd_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) cnt_d = '0;
    else if (state_q == F_CONV) cnt_d = cnt_q + StepW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bin_q <= (value_i > MaxValue) ? MaxValue : value_i;
      bcd_q <= '0;
    end else if (state_q == F_CONV) begin
      bin_q <= {bin_q[ValueW-3:0], 2'b00};
      bcd_q <= step2;
    end
  end

endmodule

>>> hdl/ntw_back.sv
// Back end: walks the token mask of one BCD number, one token per cycle while
// out_ready_i is high. Depends on ntw_pkg.
module ntw_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fifo_empty_i,
  input  ntw_pkg::bcd_t            fifo_data_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ntw_pkg::CodeW-1:0] word_code_o,
  output logic                     last_o
);
  import ntw_pkg::*;

  logic [TokenCnt-1:0] mask_q, mask_d;
  bcd_t                bcd_q;
  logic [PosW-1:0]     pos;
  logic                fire;
  logic                load;

  always_comb begin
    pos = PosW'(TokenCnt - 1);
    for (int i = TokenCnt - 1; i >= 0; i--) begin
      if (mask_q[i]) pos = PosW'(i);
    end
  end

  assign out_valid_o = (mask_q != '0);
  assign last_o      = (pos == PosW'(TokenCnt - 1));
  assign word_code_o = token_code(bcd_q, pos);
  assign fire        = out_valid_o && out_ready_i;
  assign load        = !out_valid_o || (fire && last_o);
  assign pop_o       = load && !fifo_empty_i;

  always_comb begin
    mask_d = mask_q;
    if (load) mask_d = fifo_empty_i ? '0 : token_mask(fifo_data_i);
    else if (fire) mask_d[pos] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) bcd_q <= fifo_data_i;
  end

endmodule

>>> hdl/number_to_word_tokens.sv
// Top level: reads a number 0..999999999 out as English word tokens.
// The front converts an accepted item to BCD two bits per cycle, the queue
// holds it and the back emits one token per cycle while out_ready_i is high.
// The front takes a new item only once the last one's BCD goes to the queue.
// Reset: asynchronous, active low; clears control state and upper_case.
// Depends on ntw_pkg, ntw_front, ntw_fifo, ntw_back.
module number_to_word_tokens (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ntw_pkg::ValueW-1:0] value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ntw_pkg::CodeW-1:0]  word_code_o,
  output logic                      capitals_o,
  output logic                      last_o
);
  import ntw_pkg::*;

  logic upper_case_q;
  logic push;
  bcd_t push_data;
  logic fifo_full;
  logic fifo_empty;
  bcd_t fifo_data;
  logic pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_case_q <= 1'b0;
    end else if (cfg_we_i) begin
      upper_case_q <= cfg_wdata_i;
    end
  end

  assign capitals_o = upper_case_q;

  ntw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .push_o      (push),
    .push_data_o (push_data),
    .fifo_full_i (fifo_full)
  );

  ntw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .empty_o     (fifo_empty),
    .pop_data_o  (fifo_data)
  );

  ntw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_data_i  (fifo_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .word_code_o  (word_code_o),
    .last_o       (last_o)
  );

endmodule

>>> tb/ntw_token_checker.sv
`timescale 1ns / 100ps
// ntw_token_checker: watches the number and token channels of number_to_word_tokens,
// works out the word tokens due for each accepted number and compares them field by field.
// Depends on ntw_pkg; instantiated by tb beside the block.
module ntw_token_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [ntw_pkg::ValueW-1:0] value_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [ntw_pkg::CodeW-1:0]  word_code_i,
  input  logic                       capitals_i,
  input  logic                       last_i,
  output int                         fail_cnt_o,
  output int                         pending_o,
  output int                         words_seen_o
);
  import ntw_pkg::*;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             caps;
    logic             last;
  } word_t;

  word_t words_due[$];
  word_t want;
  logic  caps_q;
  int    fails = 0;
  int    seen = 0;

  assign fail_cnt_o   = fails;
  assign words_seen_o = seen;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    $display("%0t ntw_token_checker: %s got %0d expected %0d", $time, what, got, exp_v);
    fails++;
  endtask

  function automatic void push_word(input logic [CodeW-1:0] code, input logic is_last);
    word_t w;
    w.code = code;
    w.caps = caps_q;
    w.last = is_last;
    words_due.push_back(w);
  endfunction

  function automatic void push_group(input int unsigned grp);
    int unsigned h;
    int unsigned t;
    int unsigned o;
    h = grp / 100;
    t = (grp % 100) / 10;
    o = grp % 10;
    if (h != 0) begin
      push_word(CodeW'(h), 1'b0);
      push_word(CodeHundred, 1'b0);
    end
    if (t == 1) begin
      push_word(CodeTeenBase + CodeW'(o), 1'b0);
    end else begin
      if (t > 1) push_word(CodeTensBase + CodeW'(t), 1'b0);
      if (o != 0) push_word(CodeW'(o), 1'b0);
    end
  endfunction

  // values above range read out as the maximum
  function automatic void predict_words(input logic [ValueW-1:0] value);
    int unsigned n;
    n = (value > MaxValue) ? int'(MaxValue) : int'(value);
    if (n / 1000000 != 0) begin
      push_group(n / 1000000);
      push_word(CodeMillion, 1'b0);
    end
    if ((n / 1000) % 1000 != 0) begin
      push_group((n / 1000) % 1000);
      push_word(CodeThousand, 1'b0);
    end
    if (n % 1000 != 0) push_group(n % 1000);
    push_word(CodeEol, 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_q = 1'b0;
      words_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) caps_q = cfg_wdata_i;
      // compare before predicting: a token never belongs to a number taken this cycle
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (words_due.size() == 0) begin
          report("token with none due, word_code", 32'(word_code_i), 32'(0));
        end else begin
          want = words_due.pop_front();
          if (word_code_i !== want.code) begin
            report("word_code", 32'(word_code_i), 32'(want.code));
          end
          if (capitals_i !== want.caps) report("capitals", 32'(capitals_i), 32'(want.caps));
          if (last_i !== want.last) report("last", 32'(last_i), 32'(want.last));
        end
      end
      if (in_valid_i && in_ready_i) predict_words(value_i);
      pending_o <= words_due.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// tb: drives numbers and the upper-case register into number_to_word_tokens with random
// idling on both channels; ntw_token_checker does the checking. Depends on ntw_pkg.
module tb;
  import ntw_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ValueW-1:0] value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CodeW-1:0]  word_code_o;
  logic              capitals_o;
  logic              last_o;

  int fail_cnt;
  int words_pending;
  int words_seen;
  int items_sent = 0;
  bit idling_on = 1'b1;

  int unsigned directed_vals[25] = '{
    0, 1, 9, 10, 11, 15, 19, 20, 21, 45, 99, 100, 101, 110, 119, 999, 1000, 1001,
    1000000, 1000010, 12000000, 305060019, 999999999, 1000000000, 32'h3FFF_FFFF
  };

  number_to_word_tokens u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .word_code_o(word_code_o),
    .capitals_o (capitals_o),
    .last_o     (last_o)
  );

  ntw_token_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .value_i     (value_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_code_i (word_code_o),
    .capitals_i  (capitals_o),
    .last_i      (last_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (words_pending),
    .words_seen_o(words_seen)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= !(idling_on && $urandom_range(99) < 12);
  end

  task automatic send_value(input logic [ValueW-1:0] v);
    if (idling_on) begin
      while ($urandom_range(99) < 12) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // hold off the sender until every token due has come out
  task automatic drain_words();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_caps(input logic v);
    drain_words();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int unsigned random_group();
    int unsigned h;
    int unsigned t;
    int unsigned o;
    h = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 9);
    t = ($urandom_range(9) < 3) ? 0 : (($urandom_range(9) < 2) ? 1 : $urandom_range(1, 9));
    o = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 9);
    return h * 100 + t * 10 + o;
  endfunction

  // mostly numbers built group by group with zero groups and digits, some raw 30-bit
  function automatic logic [ValueW-1:0] random_value();
    int unsigned mil;
    int unsigned thou;
    int unsigned unit;
    if ($urandom_range(99) < 10) return ValueW'($urandom);
    mil  = ($urandom_range(3) == 0) ? 0 : random_group();
    thou = ($urandom_range(3) == 0) ? 0 : random_group();
    unit = ($urandom_range(3) == 0) ? 0 : random_group();
    return ValueW'(mil * 1000000 + thou * 1000 + unit);
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_caps(1'b1);
    foreach (directed_vals[i]) send_value(ValueW'(directed_vals[i]));

    write_caps(1'b0);
    for (int i = 0; i < 320; i++) begin
      if (i == 70) drain_words();
      if (i == 140) write_caps(1'b1);
      if (i == 240) write_caps(1'b0);
      idling_on = !(i >= 150 && i < 230);
      send_value(random_value());
    end

    drain_words();
    repeat (20) @(posedge clk_i);
    $display("covered %0d numbers, %0d tokens checked", items_sent, words_seen);
    $display("upper-case set 1, 0, 1, 0; zero, teens, tens, scales and saturation included");
    if (fail_cnt == 0) begin
      $display("number_to_word_tokens: match");
    end else begin
      $display("number_to_word_tokens: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("number_to_word_tokens: mismatch");
    $finish;
  end

endmodule
